FILE: rtl/core/b32e_pkg.sv
// Base32 encoder package: shared types, ASCII constants and the symbol map.
// No dependencies; every rtl/core module refers to it by scoped names.
`default_nettype none

package b32e_pkg;

  localparam logic [6:0] CHAR_A      = 7'h41;  // 'A'
  localparam logic [6:0] CHAR_J      = 7'h4A;  // 'J'
  localparam logic [6:0] CHAR_P      = 7'h50;  // 'P'
  localparam logic [6:0] CHAR_2      = 7'h32;  // '2'
  localparam logic [6:0] LOWER_OFFS  = 7'd32;  // 'a' - 'A'
  localparam logic [6:0] SYM_J_BASE  = 7'd8;
  localparam logic [6:0] SYM_P_BASE  = 7'd13;
  localparam logic [6:0] SYM_D_BASE  = 7'd24;
  localparam logic [2:0] CARRY_MAX   = 3'd4;
  localparam logic [3:0] BYTE_BITS   = 4'd8;

  typedef struct packed {
    logic [3:0] bits;
    logic [2:0] cnt;
  } carry_t;

  // One byte cut into up to three 5-bit symbols.
  typedef struct packed {
    logic [2:0][4:0] sym;   // sym[0] goes out first
    logic [1:0]      cnt;
    logic            last;
  } slice_t;

  // Symbol offered by the group buffer.
  typedef struct packed {
    logic       valid;
    logic [4:0] sym;
    logic       last_char;
  } grp_out_t;

  function automatic logic [6:0] sym_to_ascii(input logic [4:0] v, input logic lower);
    logic [6:0] v7;
    logic [6:0] code;
    logic [6:0] offs;
    v7   = {2'b00, v};
    offs = lower ? LOWER_OFFS : 7'd0;
    case (v) inside
      [5'd0:5'd7]:   code = CHAR_A + v7 + offs;
      [5'd8:5'd12]:  code = CHAR_J + (v7 - SYM_J_BASE) + offs;
      [5'd13:5'd23]: code = CHAR_P + (v7 - SYM_P_BASE) + offs;
      default:       code = CHAR_2 + (v7 - SYM_D_BASE);
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/b32e_slicer.sv
// Combinational bit slicer: joins pending bits with a new byte and cuts symbols.
// Depends on b32e_pkg.
`default_nettype none

module b32e_slicer (
  input  wire b32e_pkg::carry_t carry_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic [3:0]       final_bits_i,
  output b32e_pkg::slice_t      slice_o,
  output b32e_pkg::carry_t      carry_o
);

  logic [2:0]  c;
  logic [14:0] window;
  logic [3:0]  fb;
  logic [3:0]  total;
  logic [1:0]  n;
  logic [3:0]  used;
  logic [3:0]  rem;
  logic [7:0]  keep_mask;

  always_comb begin
    c      = (carry_i.cnt > b32e_pkg::CARRY_MAX) ? b32e_pkg::CARRY_MAX : carry_i.cnt;
    // pending bits then the whole byte, left-justified in 15 bits
    window = {3'b000, carry_i.bits, data_byte_i} << (3'd7 - c);
    fb     = (final_bits_i > b32e_pkg::BYTE_BITS) ? b32e_pkg::BYTE_BITS : final_bits_i;

    if (last_byte_i) begin
      total = {1'b0, c} + fb;
      case (total) inside
        4'd0:          n = 2'd0;
        [4'd1:4'd5]:   n = 2'd1;
        [4'd6:4'd10]:  n = 2'd2;
        default:       n = 2'd3;
      endcase
    end else begin
      total = {1'b0, c} + b32e_pkg::BYTE_BITS;
      n     = (total >= 4'd10) ? 2'd2 : 2'd1;
    end

    case (n)
      2'd1:    used = 4'd5;
      2'd2:    used = 4'd10;
      2'd3:    used = 4'd15;
      default: used = 4'd0;
    endcase
    rem       = total - used;
    keep_mask = (8'd1 << rem[2:0]) - 8'd1;

    slice_o.sym[0] = window[14:10];
    slice_o.sym[1] = window[9:5];
    slice_o.sym[2] = window[4:0];
    slice_o.cnt    = n;
    slice_o.last   = last_byte_i;

    if (last_byte_i) begin
      carry_o.bits = 4'd0;
      carry_o.cnt  = 3'd0;
    end else begin
      carry_o.bits = data_byte_i[3:0] & keep_mask[3:0];
      carry_o.cnt  = rem[2:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/b32e_group_buf.sv
// Group buffer: holds the symbols of one byte and hands them out one per take.
// Depends on b32e_pkg.
`default_nettype none

module b32e_group_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire b32e_pkg::slice_t   slice_i,
  input  wire logic               take_i,
  output b32e_pkg::grp_out_t      grp_o,
  output logic                    stall_o
);

  logic            vld_q, vld_d;
  logic [1:0]      idx_q, idx_d;
  logic [2:0][4:0] sym_q;
  logic [1:0]      cnt_q;
  logic            last_q;
  logic            final_sym;
  logic            move;
  logic            drain;
  logic [4:0]      cur_sym;

  always_comb begin
    case (idx_q)
      2'd0:    cur_sym = sym_q[0];
      2'd1:    cur_sym = sym_q[1];
      default: cur_sym = sym_q[2];
    endcase
    final_sym = (idx_q == (cnt_q - 2'd1));
    move      = vld_q && take_i;
    drain     = move && final_sym;
    stall_o   = vld_q && !drain;

    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = (slice_i.cnt != 2'd0);
      idx_d = 2'd0;
    end else if (drain) begin
      vld_d = 1'b0;
    end else if (move) begin
      idx_d = idx_q + 2'd1;
    end

    grp_o.valid     = vld_q;
    grp_o.sym       = cur_sym;
    grp_o.last_char = last_q && final_sym;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  // payload: capture on load only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sym_q  <= slice_i.sym;
      cnt_q  <= slice_i.cnt;
      last_q <= slice_i.last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/base32_bit_encoder.sv
// Top level of the base32 bit-stream encoder: carry state, config register,
// output register and assertions. Depends on b32e_pkg, b32e_slicer, b32e_group_buf.
`default_nettype none

// Turns a byte stream into base32 ASCII characters (A-H, J-N, P-Z, 2-9),
// reading each byte most significant bit first, five bits per character.
// Bits that do not fill a character are carried to the next byte. A beat
// with last_byte_i set closes the message: final_bits_i (0..8, larger
// values count as 8) says how many of its bits belong to the message, the
// remaining characters are padded with the byte's unused bits, then zeros,
// and last_char_o marks the final one. cfg_we_i/cfg_wdata_i write the
// lowercase bit; write it only while the block is idle. Timing: a byte is
// sliced as it enters, its 0..3 characters sit in a group buffer, and the
// output register emits one character per cycle while out_stall_i is low.
// An ordinary byte yields 1 or 2 characters, the final one up to 3. A new
// byte is accepted while the group buffer is empty or hands out the last
// character of the previous byte. The first character of a byte passes
// from the group buffer through the output register to the output. Both
// channels use valid/stall; a beat moves when valid is high and stall low.
module base32_bit_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // input beats
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic [3:0] final_bits_i,
  // result beats
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      char_code_o,
  output logic            last_char_o
);

  logic               lowercase_q;
  b32e_pkg::carry_t   carry_q;
  b32e_pkg::carry_t   carry_d;
  b32e_pkg::slice_t   slice;
  b32e_pkg::grp_out_t grp;
  logic               grp_stall;
  logic               in_acc;
  logic               out_take;
  logic               out_valid_q, out_valid_d;
  logic [6:0]         char_q;
  logic               last_q;

  // accept a byte whenever the group buffer is empty or drains this cycle
  assign in_stall_o = grp_stall;
  assign in_acc     = in_valid_i && !grp_stall;

  // output register frees up when empty or when its beat is taken
  assign out_take    = !out_valid_q || !out_stall_i;
  assign out_valid_d = out_take ? grp.valid : out_valid_q;

  b32e_slicer u_slicer (
    .carry_i      (carry_q),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .final_bits_i (final_bits_i),
    .slice_o      (slice),
    .carry_o      (carry_d)
  );

  b32e_group_buf u_group_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .slice_i (slice),
    .take_i  (out_take),
    .grp_o   (grp),
    .stall_o (grp_stall)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowercase_q <= 1'b0;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lowercase_q <= cfg_wdata_i;
      end
      // advance the pending bits with every accepted byte
      if (in_acc) begin
        carry_q <= carry_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // map the symbol to ASCII as it enters the output register
  always_ff @(posedge clk_i) begin
    if (out_take && grp.valid) begin
      char_q <= b32e_pkg::sym_to_ascii(grp.sym, lowercase_q);
      last_q <= grp.last_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // a closing byte leaves nothing pending
  a_last_clears_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> carry_q.cnt == 3'd0 && carry_q.bits == 4'd0)
    else $error("carry not cleared after final byte");

  // never more than four bits pending
  a_carry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carry_q.cnt <= b32e_pkg::CARRY_MAX)
    else $error("pending bit count out of range");

  // a held output beat with a loaded group buffer must back-pressure the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp.valid && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input accepted while group buffer blocked");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for base32_bit_encoder: byte beats in, ASCII characters out.
// Depends only on the encoder RTL; a class here predicts every character.

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_BYTES    = 56;

  // ASCII anchors of the four alphabet runs
  localparam logic [6:0] ASCII_A     = 7'h41;
  localparam logic [6:0] ASCII_J     = 7'h4A;
  localparam logic [6:0] ASCII_P     = 7'h50;
  localparam logic [6:0] ASCII_2     = 7'h32;
  localparam logic [6:0] CASE_OFFSET = 7'd32;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_beat_t;

  // Holds the encoder's carry and case bit and the characters still owed.
  class base32_char_board;
    bit         lowercase;
    logic [3:0] carry_bits;
    logic [2:0] carry_count;
    char_beat_t expected_chars[$];
    int         failures;
    int         chars_checked;
    int         bytes_noted;
    int         messages;

    function new();
      lowercase = 1'b0;
      carry_bits = '0;
      carry_count = '0;
      failures = 0;
      chars_checked = 0;
      bytes_noted = 0;
      messages = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function logic [6:0] symbol_ascii(logic [4:0] v);
      logic [6:0] shift;
      logic [6:0] v7;
      shift = lowercase ? CASE_OFFSET : 7'd0;
      v7 = {2'b00, v};
      if (v < 5'd8) return ASCII_A + v7 + shift;
      if (v < 5'd13) return ASCII_J + (v7 - 7'd8) + shift;
      if (v < 5'd24) return ASCII_P + (v7 - 7'd13) + shift;
      return ASCII_2 + (v7 - 7'd24);
    endfunction

    // Cut the carried bits plus this byte into 5-bit symbols, oldest first.
    function void note_byte(logic [7:0] data, logic last, logic [3:0] fbits);
      logic [14:0] window;
      char_beat_t  beat;
      int          total;
      int          n;
      int          r;
      window = {3'b000, carry_bits, data} << (7 - carry_count);
      if (last) begin
        total = carry_count + ((fbits > 4'd8) ? 8 : fbits);
        n = (total + 4) / 5;
      end else begin
        total = carry_count + 8;
        n = total / 5;
      end
      for (int k = 0; k < n; k++) begin
        beat.code = symbol_ascii(5'(window >> (10 - 5 * k)));
        beat.last = last && (k == n - 1);
        expected_chars.push_back(beat);
      end
      if (last) begin
        carry_bits = '0;
        carry_count = '0;
        messages++;
      end else begin
        r = total - 5 * n;
        carry_count = 3'(r);
        carry_bits = 4'(data & ((8'd1 << r) - 8'd1));
      end
      bytes_noted++;
    endfunction

    function void flag(string what, int exp_v, int act_v);
      if (failures < 10)
        $display("mismatch: %s expected %0h got %0h", what, exp_v, act_v);
      failures++;
    endfunction

    function void check_char(logic [6:0] code, logic last);
      char_beat_t exp_beat;
      if (expected_chars.size() == 0) begin
        flag("character with nothing owed, code", 0, code);
        return;
      end
      exp_beat = expected_chars.pop_front();
      chars_checked++;
      if (code !== exp_beat.code) flag("char_code", exp_beat.code, code);
      if (last !== exp_beat.last) flag("last_char", exp_beat.last, last);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic [3:0] final_bits_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] char_code_o;
  logic       last_char_o;

  base32_char_board board = new();
  bit idling_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  base32_bit_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .final_bits_i (final_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  // Result side: check every accepted character, throttle with stall bursts,
  // and stop the run if the handshakes go quiet for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_char(char_code_o, last_char_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles++;
      end
      // hold stall for the rest of a burst, else maybe start a new one
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (idling_on && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  // Offer one byte beat and wait for it to be taken. Valid stays high on
  // return so back-to-back beats never drop it within a time step.
  task automatic send_byte(input logic [7:0] data, input logic last, input logic [3:0] fbits);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    final_bits_i <= fbits;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(data, last, fbits);
  endtask

  // Drop valid, let every owed character drain, then wait out DRAIN_CYCLES
  // in case the last byte produced nothing.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lowercase(input logic val);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.lowercase = val;
  endtask

  // A message is a run of full bytes closed by a final byte. Most final
  // bytes state 1..8 bits; the rest state none or an oversized count.
  task automatic send_message(inout int sent);
    int len;
    int pick;
    logic [3:0] fbits;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), 1'b0, 4'($urandom));
      sent++;
    end
    pick = $urandom_range(0, 19);
    if (pick < 3) fbits = 4'd0;
    else if (pick < 6) fbits = 4'($urandom_range(9, 15));
    else fbits = 4'($urandom_range(1, 8));
    send_byte(8'($urandom), 1'b1, fbits);
    sent++;
  endtask

  initial begin
    int sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_lowercase(1'b0);

    // Directed: single-byte messages at the extremes of final_bits
    send_byte(8'h00, 1'b1, 4'd8);
    send_byte(8'hFF, 1'b1, 4'd8);
    send_byte(8'h80, 1'b1, 4'd1);   // one bit, rest zero padded
    send_byte(8'h5A, 1'b1, 4'd0);   // empty message, no character at all
    send_byte(8'hA5, 1'b1, 4'd15);  // oversized count acts as eight
    // full bytes that land on a group boundary, then a short tail
    send_byte(8'h00, 1'b0, 4'd0);
    send_byte(8'hFF, 1'b0, 4'd15);
    send_byte(8'h12, 1'b0, 4'd3);
    send_byte(8'h34, 1'b0, 4'd7);
    send_byte(8'h56, 1'b0, 4'd9);
    send_byte(8'hE0, 1'b1, 4'd3);
    // pending bits with a zero-bit final byte: pad from the unused byte bits
    send_byte(8'hFF, 1'b0, 4'd0);
    send_byte(8'hFF, 1'b1, 4'd0);
    // carry of four plus a full final byte gives three characters
    send_byte(8'hC3, 1'b0, 4'd0);
    send_byte(8'h3C, 1'b0, 4'd0);
    send_byte(8'h99, 1'b0, 4'd0);
    send_byte(8'h66, 1'b1, 4'd8);
    // carry of one with seven final bits
    send_byte(8'h01, 1'b0, 4'd0);
    send_byte(8'h02, 1'b0, 4'd0);
    send_byte(8'h7F, 1'b1, 4'd7);
    drain();

    // Random phases: alternate the case bit; one quiet phase in the
    // middle and the closing phase run without any idling.
    for (int phase = 0; phase < 4; phase++) begin
      write_lowercase(phase[0] ? 1'b0 : 1'b1);
      idling_on = (phase == 0) || (phase == 2);
      sent = 0;
      while (sent < PHASE_BYTES) send_message(sent);
      drain();
    end

    $display("sent %0d bytes in %0d messages, checked %0d characters",
             board.bytes_noted, board.messages, board.chars_checked);
    $display("case bit run both ways; %0d mismatches, %0d characters still owed",
             board.failures, board.pending());
    if (board.failures == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
